// ----- sv/bpc_pkg.sv -----
`timescale 1ns / 1ps
// bpc_pkg: shared types and codes for the button press classifier.
// No dependencies.

package bpc_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PDEB  = 3'd1,
    PH_SHORT = 3'd2,
    PH_LONG  = 3'd3,
    PH_RDEB  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } press_event_e;

  localparam logic REG_DEBOUNCE_MS   = 1'b0;
  localparam logic REG_LONG_PRESS_MS = 1'b1;

  localparam int unsigned CfgAddrBits = 1;
  localparam int unsigned CfgDataBits = 16;

  localparam logic [15:0] DebounceMsRst  = 16'd50;
  localparam logic [15:0] LongPressMsRst = 16'd1000;

endpackage

// ----- sv/button_press_classifier.sv -----
`timescale 1ns / 1ps
// button_press_classifier: debounced short/long press detector, top level.
// Depends on bpc_pkg.
//
// Usage:
//   Slave stream: one beat per poll of an active-low button pin, carrying the
//   raw pin level and a free-running millisecond timestamp.
//   Master stream: exactly one beat per input beat, carrying the press event
//   (none, short press completed, long press completed).
//   Config port: cfg_we_i writes cfg_wdata_i into register cfg_addr_i
//   (0 debounce time, 1 long press threshold), in milliseconds.
// Output: the result is registered and appears in the cycle after the input beat is taken.
// Throughput: one beat per cycle while the receiver takes each result. The phase
//   machine and both elapsed-time compares finish within the accepting cycle,
//   and the result is held in a single output register.
// Stall: while the output register holds a beat that the receiver does not
//   take, s_axis_tready is low; it rises in the cycle the beat leaves, so a
//   new poll is taken in the same cycle as the old result is drained.
// Reset: phase returns to idle, timestamps to zero, debounce time to 50 ms
//   and long press threshold to 1000 ms; the output register empties.

module button_press_classifier #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [39:0]                       s_axis_tdata,  // [0] pin_level, [32:1] now_ms
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // [1:0] press_event
  input  logic                              cfg_we_i,
  input  logic [bpc_pkg::CfgAddrBits-1:0]   cfg_addr_i,
  input  logic [bpc_pkg::CfgDataBits-1:0]   cfg_wdata_i
);
  import bpc_pkg::*;

  logic [15:0] debounce_q, long_press_q;
  phase_e      phase_q, phase_d;
  logic [TIME_BITS-1:0] deb_start_q, deb_start_d;
  logic [TIME_BITS-1:0] prs_start_q, prs_start_d;
  press_event_e ev_q, ev_d;
  logic         out_valid_q;

  logic                 in_acc;
  logic                 pressed;
  logic [TIME_BITS-1:0] now_w;
  logic [TIME_BITS-1:0] deb_elapsed, prs_elapsed;
  logic                 deb_done, held_long;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign pressed       = !s_axis_tdata[0];
  assign now_w         = TIME_BITS'(s_axis_tdata[32:1]);

  assign deb_elapsed = now_w - deb_start_q;
  assign prs_elapsed = now_w - prs_start_q;
  assign deb_done    = deb_elapsed >= TIME_BITS'(debounce_q);
  assign held_long   = prs_elapsed >= TIME_BITS'(long_press_q);

  // next state
  always_comb begin
    phase_d     = phase_q;
    deb_start_d = deb_start_q;
    prs_start_d = prs_start_q;
    case (phase_q)
      PH_PDEB: begin
        if (!pressed) begin
          phase_d = PH_IDLE;
        end else if (deb_done) begin
          prs_start_d = now_w;
          phase_d     = PH_SHORT;
        end
      end
      PH_SHORT: begin
        if (!pressed) begin
          phase_d     = PH_RDEB;
          deb_start_d = now_w;
        end else if (held_long) begin
          phase_d = PH_LONG;
        end
      end
      PH_LONG: begin
        if (!pressed) begin
          phase_d     = PH_RDEB;
          deb_start_d = now_w;
        end
      end
      PH_RDEB: begin
        if (pressed) begin
          phase_d     = held_long ? PH_LONG : PH_SHORT;
          deb_start_d = now_w;
        end else if (deb_done) begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        if (pressed) begin
          deb_start_d = now_w;
          phase_d     = PH_PDEB;
        end else begin
          phase_d = PH_IDLE;
        end
      end
    endcase
  end

  // result
  always_comb begin
    case (phase_q)
      PH_RDEB: begin
        if (!pressed && deb_done) begin
          ev_d = held_long ? EV_LONG : EV_SHORT;
        end else begin
          ev_d = EV_NONE;
        end
      end
      default: ev_d = EV_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DebounceMsRst;
      long_press_q <= LongPressMsRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_DEBOUNCE_MS:   debounce_q   <= cfg_wdata_i;
        REG_LONG_PRESS_MS: long_press_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      deb_start_q <= '0;
      prs_start_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q     <= phase_d;
        deb_start_q <= deb_start_d;
        prs_start_q <= prs_start_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ev_q <= ev_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, ev_q};

  a_event_only_from_rdeb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && phase_q != PH_RDEB |=> ev_q == EV_NONE)
    else $error("press event outside release debounce");

  a_event_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && ev_d != EV_NONE |=> phase_q == PH_IDLE)
    else $error("phase not idle after press event");

  a_idle_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && phase_q == PH_IDLE && !pressed |=> phase_q == PH_IDLE)
    else $error("left idle without a press");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> out_valid_q)
    else $error("input stalled with empty output register");

endmodule
